@@ src/rbfsa_pkg.sv @@
// ----------------------------------------------------------------------------
// rbfsa_pkg
// Shared types, field widths and codes of the block allocator.
// ----------------------------------------------------------------------------
package rbfsa_pkg;

  localparam int POOL_BLOCKS_DFLT = 4096;
  localparam int POOL_SIZE_W      = 13;
  localparam int POOL_SIZE_RST    = 4096;
  localparam int CMD_W            = 3;
  localparam int COUNT_W          = 13;
  localparam int BLOCK_W          = 12;
  localparam int STATUS_W         = 3;
  localparam int QUEUE_DEPTH      = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_QUERY     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RESERVE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_UNRESERVE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ALLOC     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FREE      = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_ENOUGH  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNRES_LARGE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_RES      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_ID      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DOUBLE_FREE = 3'd5;

  // classified operation
  typedef enum logic [4:0] {
    OP_QUERY     = 5'b00001,
    OP_RESERVE   = 5'b00010,
    OP_UNRESERVE = 5'b00100,
    OP_ALLOC     = 5'b01000,
    OP_FREE      = 5'b10000
  } op_t;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [COUNT_W-1:0] count;
    logic [BLOCK_W-1:0] block_in;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                can_reserve;
    logic [BLOCK_W-1:0]  block_out;
    logic [BLOCK_W-1:0]  free_count;
    logic [BLOCK_W-1:0]  reserved_count;
  } out_t;

  typedef struct packed {
    op_t                op;
    logic [COUNT_W-1:0] count;
    logic [BLOCK_W-1:0] block_in;
    logic               id_bad;
  } cmdq_t;

endpackage

@@ src/rbfsa_ram.sv @@
// ----------------------------------------------------------------------------
// rbfsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rbfsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/rbfsa_fifo.sv @@
// ----------------------------------------------------------------------------
// rbfsa_fifo
// Small register queue used between front and back and at the result side.
// ----------------------------------------------------------------------------
module rbfsa_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW   = $clog2(DEPTH),
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rd_ptr_r];

  // advance pointers with wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // store payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ src/rbfsa_front.sv @@
// ----------------------------------------------------------------------------
// rbfsa_front
// Accepts commands, classifies them and checks the block id range, then
// queues them for the execution back end.
// ----------------------------------------------------------------------------
module rbfsa_front import rbfsa_pkg::*; #(
  parameter int POOL_BLOCKS = POOL_BLOCKS_DFLT,
  localparam int CNT_W      = $clog2(POOL_BLOCKS + 1),
  localparam int IDC_W      = (CNT_W > BLOCK_W) ? CNT_W : BLOCK_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  in_t              in_data,
  input  logic [CNT_W-1:0] pool_n,
  output logic             q_valid,
  input  logic             q_pop,
  output cmdq_t            q_entry
);

  cmdq_t entry;
  logic  q_empty;

  // decode command into operation kind; unknown codes behave as a query
  always_comb begin
    unique case (in_data.command)
      CMD_RESERVE:   entry.op = OP_RESERVE;
      CMD_UNRESERVE: entry.op = OP_UNRESERVE;
      CMD_ALLOC:     entry.op = OP_ALLOC;
      CMD_FREE:      entry.op = OP_FREE;
      default:       entry.op = OP_QUERY;
    endcase
    entry.count    = in_data.count;
    entry.block_in = in_data.block_in;
    // block zero and ids beyond the pool are rejected
    entry.id_bad   = (in_data.block_in == '0) ||
                     (IDC_W'(in_data.block_in) >= IDC_W'(pool_n));
  end

  rbfsa_fifo #(
    .WIDTH ($bits(cmdq_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (entry),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_entry),
    .empty (q_empty)
  );

  assign q_valid = !q_empty;

endmodule

@@ src/rbfsa_back.sv @@
// ----------------------------------------------------------------------------
// rbfsa_back
// Executes queued commands against the free stack, reservation counter and
// in-use bits, and emits one result per command.
// ----------------------------------------------------------------------------
module rbfsa_back import rbfsa_pkg::*; #(
  parameter int POOL_BLOCKS = POOL_BLOCKS_DFLT,
  localparam int CNT_W      = $clog2(POOL_BLOCKS + 1),
  localparam int ID_W       = $clog2(POOL_BLOCKS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             init,
  input  logic [CNT_W-1:0] pool_n,
  input  logic             q_valid,
  input  cmdq_t            q_entry,
  output logic             q_pop,
  input  logic             res_full,
  output logic             res_push,
  output out_t             res_data
);

  localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int N_RST = (POOL_SIZE_RST > POOL_BLOCKS) ? POOL_BLOCKS : POOL_SIZE_RST;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WAIT = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] depth_r, depth_nxt;
  logic [CNT_W-1:0] res_r, res_nxt;
  // lowest stack depth reached since init; entries below it are untouched
  logic [CNT_W-1:0] lw_r, lw_nxt;

  logic [CNT_W-1:0] avail, top_idx, fresh_id, seen_lim, blk_c;
  logic             can, finish;
  logic [STATUS_W-1:0] status;
  logic [BLOCK_W-1:0]  block_out;
  logic [ID_W-1:0]  alloc_id, stack_rdata, stack_wdata;
  logic             stack_we, bits_we;
  logic [0:0]       bits_wdata, bits_rdata;
  logic [ID_W-1:0]  bits_waddr;

  assign avail    = depth_r - res_r;
  assign can      = CMP_W'(avail) >= CMP_W'(q_entry.count);
  assign top_idx  = depth_r - CNT_W'(1);
  assign fresh_id = pool_n - CNT_W'(1) - top_idx;
  assign seen_lim = pool_n - CNT_W'(1) - lw_r;
  assign blk_c    = CNT_W'(q_entry.block_in);
  assign alloc_id = (top_idx < lw_r) ? ID_W'(fresh_id) : stack_rdata;

  // free stack: read the top entry, write on free
  rbfsa_ram #(
    .WIDTH (ID_W),
    .DEPTH (POOL_BLOCKS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stack_we),
    .waddr (ID_W'(depth_r)),
    .wdata (stack_wdata),
    .raddr (ID_W'(top_idx)),
    .rdata (stack_rdata)
  );

  // in-use bits: read at the freed id, write on allocate and free
  rbfsa_ram #(
    .WIDTH (1),
    .DEPTH (POOL_BLOCKS)
  ) u_bits_ram (
    .clk   (clk),
    .we    (bits_we),
    .waddr (bits_waddr),
    .wdata (bits_wdata),
    .raddr (ID_W'(q_entry.block_in)),
    .rdata (bits_rdata)
  );

  // execute the command at the head of the queue
  always_comb begin
    state_nxt   = state_r;
    depth_nxt   = depth_r;
    res_nxt     = res_r;
    lw_nxt      = lw_r;
    finish      = 1'b0;
    status      = ST_OK;
    block_out   = '0;
    stack_we    = 1'b0;
    stack_wdata = ID_W'(q_entry.block_in);
    bits_we     = 1'b0;
    bits_wdata  = 1'b0;
    bits_waddr  = ID_W'(q_entry.block_in);
    unique case (state_r)
      S_IDLE: begin
        if (q_valid && !res_full) begin
          finish = 1'b1;
          case (q_entry.op)
            OP_RESERVE: begin
              if (can) begin
                res_nxt = res_r + CNT_W'(q_entry.count);
              end else begin
                status = ST_NOT_ENOUGH;
              end
            end
            OP_UNRESERVE: begin
              if (CMP_W'(q_entry.count) > CMP_W'(res_r)) begin
                status = ST_UNRES_LARGE;
              end else begin
                res_nxt = res_r - CNT_W'(q_entry.count);
              end
            end
            OP_ALLOC: begin
              if (res_r == '0) begin
                status = ST_NO_RES;
              end else if (depth_r == '0) begin
                status = ST_NOT_ENOUGH;
              end else begin
                finish    = 1'b0;
                state_nxt = S_WAIT;
              end
            end
            OP_FREE: begin
              if (q_entry.id_bad || (depth_r >= CNT_W'(POOL_BLOCKS))) begin
                status = ST_BAD_ID;
              end else begin
                finish    = 1'b0;
                state_nxt = S_WAIT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_WAIT: begin
        finish    = 1'b1;
        state_nxt = S_IDLE;
        if (q_entry.op == OP_ALLOC) begin
          // pop the top id and mark it in use
          depth_nxt  = top_idx;
          res_nxt    = res_r - CNT_W'(1);
          lw_nxt     = (top_idx < lw_r) ? top_idx : lw_r;
          bits_we    = 1'b1;
          bits_wdata = 1'b1;
          bits_waddr = alloc_id;
          block_out  = BLOCK_W'(alloc_id);
        end else begin
          // ids never handed out since init are not in use
          if ((blk_c > seen_lim) || (bits_rdata == 1'b0)) begin
            status = ST_DOUBLE_FREE;
          end else begin
            bits_we   = 1'b1;
            stack_we  = 1'b1;
            depth_nxt = depth_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign q_pop    = finish;
  assign res_push = finish;

  always_comb begin
    res_data.status         = status;
    res_data.can_reserve    = can;
    res_data.block_out      = block_out;
    res_data.free_count     = BLOCK_W'(depth_nxt);
    res_data.reserved_count = BLOCK_W'(res_nxt);
  end

  // hold state; reinitialize the pool on reset and on a size write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      depth_r <= CNT_W'(N_RST - 1);
      res_r   <= '0;
      lw_r    <= CNT_W'(N_RST - 1);
    end else if (init) begin
      state_r <= S_IDLE;
      depth_r <= pool_n - CNT_W'(1);
      res_r   <= '0;
      lw_r    <= pool_n - CNT_W'(1);
    end else begin
      state_r <= state_nxt;
      depth_r <= depth_nxt;
      res_r   <= res_nxt;
      lw_r    <= lw_nxt;
    end
  end

endmodule

@@ src/reserved_block_free_stack_allocator_core.sv @@
// ----------------------------------------------------------------------------
// reserved_block_free_stack_allocator_core
// Block-id allocator with reservation over a LIFO free stack.
//
//   channel  handshake      payload    direction
//   input    push / full    in_data    into block
//   result   pop / empty    out_data   out of block
//   config   cfg_we         cfg_wdata  into block (pool size, no read-back)
//
// Query, reserve and unreserve finish in the idle state of the back end, as
// does an allocate or free rejected on the counters or the id range; other
// allocates and frees pass through a wait state for the registered read of
// the stack RAM or in-use RAM before the pointer and bit update. A two-entry
// queue parts front and back, and a two-entry queue holds results, so either
// side may stall. Reset and a pool size write need no clearing pass: a
// low-water mark of the stack depth tells untouched stack entries and
// never-used ids apart. A size write is registered, then resets the back end.
// ----------------------------------------------------------------------------
module reserved_block_free_stack_allocator_core import rbfsa_pkg::*; #(
  parameter int POOL_BLOCKS = POOL_BLOCKS_DFLT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  in_t                    in_data,
  output logic                   empty,
  input  logic                   pop,
  output out_t                   out_data,
  input  logic                   cfg_we,
  input  logic [POOL_SIZE_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(POOL_BLOCKS + 1);
  localparam int N_RST = (POOL_SIZE_RST > POOL_BLOCKS) ? POOL_BLOCKS : POOL_SIZE_RST;

  logic [CNT_W-1:0] pool_n_r, pool_n_nxt;
  logic             init_r;
  logic             q_valid, q_pop, res_full, res_push;
  cmdq_t            q_entry;
  out_t             res_data;

  // saturate the written size to the supported range
  always_comb begin
    if (cfg_wdata == '0) begin
      pool_n_nxt = CNT_W'(1);
    end else if (int'(cfg_wdata) > POOL_BLOCKS) begin
      pool_n_nxt = CNT_W'(POOL_BLOCKS);
    end else begin
      pool_n_nxt = CNT_W'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_n_r <= CNT_W'(N_RST);
      init_r   <= 1'b0;
    end else begin
      init_r <= cfg_we;
      if (cfg_we) begin
        pool_n_r <= pool_n_nxt;
      end
    end
  end

  rbfsa_front #(
    .POOL_BLOCKS (POOL_BLOCKS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .pool_n  (pool_n_r),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_entry (q_entry)
  );

  rbfsa_back #(
    .POOL_BLOCKS (POOL_BLOCKS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .init     (init_r),
    .pool_n   (pool_n_r),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_data)
  );

  rbfsa_fifo #(
    .WIDTH ($bits(out_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_data),
    .empty (empty)
  );

endmodule

@@ dv/block_alloc_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_alloc_checker
// Watches the command and result queues of the block allocator, keeps its
// own copy of the free stack, reservation total and in-use bits, predicts
// one result per accepted command and compares every popped result in order.
// ----------------------------------------------------------------------------
module block_alloc_checker import rbfsa_pkg::*; #(
  parameter int POOL_BLOCKS = POOL_BLOCKS_DFLT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  logic                   full,
  input  in_t                    in_data,
  input  logic                   empty,
  input  logic                   pop,
  input  out_t                   out_data,
  input  logic                   cfg_we,
  input  logic [POOL_SIZE_W-1:0] cfg_wdata,
  output int unsigned            mismatch_count,
  output int unsigned            in_flight
);

  localparam int unsigned MAX_REPORTS = 40;

  // shadow allocator state
  logic [BLOCK_W-1:0]     free_ids [POOL_BLOCKS];
  bit                     in_use   [POOL_BLOCKS];
  int unsigned            depth;
  int unsigned            reserved;
  logic [POOL_SIZE_W-1:0] size_reg;

  out_t        expected_results [$];
  out_t        want;
  int unsigned result_idx;

  initial begin
    mismatch_count = 0;
    in_flight      = 0;
    result_idx     = 0;
  end

  // clamp the size register to the pool the block was built for
  function automatic int unsigned pool_limit();
    if (size_reg == '0) return 1;
    if (size_reg > POOL_BLOCKS) return POOL_BLOCKS;
    return size_reg;
  endfunction

  // refill the stack so the lowest ids sit on top
  function automatic void reload_pool();
    int n;
    n = pool_limit();
    depth = 0;
    for (int id = n - 1; id >= 1; id--) begin
      free_ids[depth] = BLOCK_W'(id);
      depth++;
    end
    foreach (in_use[i]) in_use[i] = 1'b0;
    reserved = 0;
  endfunction

  // apply one command to the shadow state and return its result
  function automatic out_t run_command(in_t cmd);
    out_t        res;
    bit          room;
    int unsigned id;
    res        = '0;
    res.status = ST_OK;
    room       = (depth - reserved) >= cmd.count;
    case (cmd.command)
      CMD_RESERVE: begin
        if (room) reserved += cmd.count;
        else res.status = ST_NOT_ENOUGH;
      end
      CMD_UNRESERVE: begin
        if (cmd.count > reserved) res.status = ST_UNRES_LARGE;
        else reserved -= cmd.count;
      end
      CMD_ALLOC: begin
        if (reserved == 0) begin
          res.status = ST_NO_RES;
        end else if (depth == 0) begin
          res.status = ST_NOT_ENOUGH;
        end else begin
          depth--;
          id = free_ids[depth];
          reserved--;
          in_use[id]    = 1'b1;
          res.block_out = BLOCK_W'(id);
        end
      end
      CMD_FREE: begin
        if (cmd.block_in == '0 || cmd.block_in >= pool_limit() || depth >= POOL_BLOCKS) begin
          res.status = ST_BAD_ID;
        end else if (!in_use[cmd.block_in]) begin
          res.status = ST_DOUBLE_FREE;
        end else begin
          in_use[cmd.block_in] = 1'b0;
          free_ids[depth]      = cmd.block_in;
          depth++;
        end
      end
      default: ;
    endcase
    res.can_reserve    = room;
    res.free_count     = BLOCK_W'(depth);
    res.reserved_count = BLOCK_W'(reserved);
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("[%0t] alloc check: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [BLOCK_W-1:0] got,
                             input logic [BLOCK_W-1:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                result_idx, name, got, exp_val));
  endtask

  // track configuration, compare popped results, then predict new commands
  always @(posedge clk) begin
    if (!rst_n) begin
      size_reg = POOL_SIZE_W'(POOL_SIZE_RST);
      reload_pool();
      expected_results.delete();
      in_flight <= 0;
    end else begin
      if (cfg_we) begin
        size_reg = cfg_wdata;
        reload_pool();
      end
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing pending", result_idx));
        end else begin
          want = expected_results.pop_front();
          check_field("status", BLOCK_W'(out_data.status), BLOCK_W'(want.status));
          check_field("can_reserve", BLOCK_W'(out_data.can_reserve),
                      BLOCK_W'(want.can_reserve));
          check_field("block_out", out_data.block_out, want.block_out);
          check_field("free_count", out_data.free_count, want.free_count);
          check_field("reserved_count", out_data.reserved_count, want.reserved_count);
        end
        result_idx++;
      end
      // append the prediction behind the results still pending
      if (push && !full) expected_results = {expected_results, run_command(in_data)};
      in_flight <= expected_results.size();
    end
  end

endmodule

@@ dv/tb_reserved_block_free_stack_allocator_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_reserved_block_free_stack_allocator_core
// Drives directed and random allocator commands over several pool sizes with
// random stalls on both queues; a checker beside the block predicts and
// compares every result, and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_reserved_block_free_stack_allocator_core;
  import rbfsa_pkg::*;

  localparam int          POOL_BLOCKS     = POOL_BLOCKS_DFLT;
  localparam int          NUM_PHASES      = 10;
  localparam int          ITEMS_PER_PHASE = 183;
  localparam int          TAIL_CYCLES     = 16;
  localparam int unsigned MAX_CYCLES      = 1000000;

  // command codes the block does not decode
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = CMD_FREE + 1'b1;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = '1;

  // pool sizes per random phase, including out-of-range values
  localparam logic [POOL_SIZE_W-1:0] PHASE_SIZES [NUM_PHASES] = '{
    13'd0, 13'd1, 13'd2, 13'h1FFF, 13'd6, 13'd4097, 13'd40, 13'd4096, 13'd300, 13'd9
  };

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   push      = 1'b0;
  logic                   pop       = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [POOL_SIZE_W-1:0] cfg_wdata = '0;
  in_t                    in_data   = '0;
  logic                   full;
  logic                   empty;
  out_t                   out_data;

  int unsigned        mismatch_count;
  int unsigned        in_flight;
  int unsigned        cycle_count = 0;
  int unsigned        pop_hold    = 0;
  bit                 pop_stalls  = 1'b1;
  int unsigned        burst_left  = 0;
  logic [BLOCK_W-1:0] live_ids [$];

  reserved_block_free_stack_allocator_core #(
    .POOL_BLOCKS (POOL_BLOCKS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  block_alloc_checker #(
    .POOL_BLOCKS (POOL_BLOCKS)
  ) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_data        (in_data),
    .empty          (empty),
    .pop            (pop),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .in_flight      (in_flight)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // end the run if it hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("[reserved_block_free_stack_allocator_core] ERROR");
      $finish;
    end
  end

  // pop with random stalls, switching between stalling and streaming stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if ($urandom_range(0, 149) == 0) pop_stalls <= !pop_stalls;
      if (pop_hold != 0) begin
        pop      <= 1'b0;
        pop_hold <= pop_hold - 1;
      end else begin
        pop <= 1'b1;
        if (pop_stalls && $urandom_range(0, 3) == 0)
          pop_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
      end
    end
  end

  // collect handed-out ids so frees can give them back
  always @(posedge clk) begin
    if (rst_n && pop && !empty && out_data.block_out != '0)
      live_ids = {live_ids, out_data.block_out};
  end

  function automatic in_t make_cmd(logic [CMD_W-1:0] command, int unsigned count,
                                   int unsigned block);
    in_t c;
    c.command  = command;
    c.count    = COUNT_W'(count);
    c.block_in = BLOCK_W'(block);
    return c;
  endfunction

  // mostly small counts, now and then any 13-bit value
  function automatic logic [COUNT_W-1:0] pick_count();
    if ($urandom_range(0, 19) == 0) return COUNT_W'($urandom);
    return COUNT_W'($urandom_range(0, 4));
  endfunction

  // weighted random command; frees mostly return ids that were handed out
  function automatic in_t random_command();
    in_t         c;
    int unsigned r;
    int unsigned pick;
    c.command  = CMD_QUERY;
    c.count    = COUNT_W'($urandom);
    c.block_in = BLOCK_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 28) begin
      c.command = CMD_RESERVE;
      c.count   = pick_count();
    end else if (r < 52) begin
      c.command = CMD_ALLOC;
    end else if (r < 78) begin
      c.command = CMD_FREE;
      if (live_ids.size() != 0 && $urandom_range(0, 9) < 8) begin
        pick       = $urandom_range(0, live_ids.size() - 1);
        c.block_in = live_ids[pick];
        live_ids.delete(pick);
      end else if ($urandom_range(0, 1) == 1) begin
        c.block_in = BLOCK_W'($urandom_range(0, 15));
      end
    end else if (r < 87) begin
      c.command = CMD_UNRESERVE;
      c.count   = pick_count();
    end else if (r < 96) begin
      c.count = pick_count();
    end else begin
      c.command = CMD_W'($urandom_range(int'(CMD_SPARE_FIRST), int'(CMD_SPARE_LAST)));
    end
    return c;
  endfunction

  // hold the transaction until the block takes it
  task automatic send_item(input in_t item);
    push    <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // idle the sender: mostly short gaps, a few long ones, some back-to-back runs
  task automatic idle_gap();
    int unsigned r;
    int unsigned gap;
    r = $urandom_range(0, 99);
    if (burst_left != 0) begin
      burst_left--;
      gap = 0;
    end else if (r < 4) begin
      burst_left = $urandom_range(20, 60);
      gap = 0;
    end else if (r < 60) begin
      gap = 0;
    end else if (r < 90) begin
      gap = $urandom_range(1, 3);
    end else if (r < 97) begin
      gap = $urandom_range(4, 8);
    end else begin
      gap = $urandom_range(15, 40);
    end
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait until every pending result has been popped
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
  endtask

  task automatic write_pool_size(input logic [POOL_SIZE_W-1:0] size);
    cfg_we    <= 1'b1;
    cfg_wdata <= size;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: a pool of ids 1 to 3
    write_pool_size(13'd4);
    send_item(make_cmd(CMD_QUERY, 0, 0));
    send_item(make_cmd(CMD_QUERY, 13'h1FFF, 12'hFFF));
    send_item(make_cmd(CMD_RESERVE, 13'h1FFF, 0));
    send_item(make_cmd(CMD_RESERVE, 2, 0));
    idle_gap();
    send_item(make_cmd(CMD_UNRESERVE, 3, 0));
    send_item(make_cmd(CMD_UNRESERVE, 1, 0));
    send_item(make_cmd(CMD_ALLOC, 0, 0));
    send_item(make_cmd(CMD_ALLOC, 0, 0));
    idle_gap();
    send_item(make_cmd(CMD_FREE, 0, 0));
    send_item(make_cmd(CMD_FREE, 0, 12'hFFF));
    send_item(make_cmd(CMD_FREE, 0, 4));
    send_item(make_cmd(CMD_FREE, 0, 2));
    send_item(make_cmd(CMD_FREE, 0, 1));
    send_item(make_cmd(CMD_FREE, 0, 1));
    idle_gap();
    send_item(make_cmd(CMD_RESERVE, 3, 0));
    send_item(make_cmd(CMD_RESERVE, 1, 0));
    send_item(make_cmd(CMD_ALLOC, 0, 0));
    send_item(make_cmd(CMD_ALLOC, 0, 0));
    send_item(make_cmd(CMD_ALLOC, 0, 0));
    send_item(make_cmd(CMD_UNRESERVE, 0, 0));
    send_item(make_cmd(CMD_QUERY, 0, 0));
    send_item(make_cmd(CMD_SPARE_FIRST, 13'h1FFF, 12'hFFF));
    send_item(make_cmd(CMD_SPARE_LAST, 0, 0));
    drain();

    // random phases, one pool size each
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_pool_size(PHASE_SIZES[p]);
      live_ids.delete();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_item(random_command());
        idle_gap();
        if (p % 3 == 0 && n == ITEMS_PER_PHASE / 2) drain();
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && in_flight == 0) begin
      $display("[reserved_block_free_stack_allocator_core] OK");
    end else begin
      $display("[reserved_block_free_stack_allocator_core] ERROR");
    end
    $finish;
  end

endmodule
